// File: sv/lgsf_pkg.sv
// ----------------------------------------------------------------------------
// lgsf_pkg: shared definitions for the linear gradient span fetch block
// Widths, register and operation codes, sequencer states and the status
// bundle passed from the index pipeline to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package lgsf_pkg;

    // Color table geometry (power-of-two sizes only)
    localparam int TABLE_AW   = 8;
    localparam int TABLE_SIZE = 1 << TABLE_AW;
    localparam int MAX_SPAN   = 64;

    // Field widths
    localparam int COORD_W   = 12;
    localparam int COUNT_W   = 7;
    localparam int TIDX_W    = 8;
    localparam int COLOR_W   = 32;
    localparam int STEP_W    = 32;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Position arithmetic, signed Q24.16 with 24 integer bits
    localparam int FRAC_W   = 16;
    localparam int POS_W    = 40;
    localparam int SCALED_W = POS_W + TABLE_AW;
    localparam int IDX_W    = SCALED_W - FRAC_W;
    localparam int MAG_W    = IDX_W;

    // Reflect works modulo 2N-1 = 2^(AW+1)-1: fold the magnitude in digits
    localparam int DIG_W  = TABLE_AW + 1;
    localparam int NDIG   = (MAG_W + DIG_W - 1) / DIG_W;
    localparam int FOLD_W = DIG_W + $clog2(NDIG);

    // Operations
    localparam logic OP_SPAN     = 1'b0;
    localparam logic OP_TABLE_WR = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_MODE  = 2'd3;

    // Spread modes (the unused code behaves as pad)
    localparam logic [MODE_W-1:0] SPREAD_PAD     = 2'd0;
    localparam logic [MODE_W-1:0] SPREAD_REPEAT  = 2'd1;
    localparam logic [MODE_W-1:0] SPREAD_REFLECT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_SUM,
        ST_LOAD,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic busy;      // any pixel still in the index stages
        logic rd_valid;  // table address ready for a read
        logic rd_last;   // that pixel closes the span
    } t_map_stat;

endpackage

`default_nettype wire

// File: sv/lgsf_ram.sv
// ----------------------------------------------------------------------------
// lgsf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held while the
// read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module lgsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic                                      i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/lgsf_map.sv
// ----------------------------------------------------------------------------
// lgsf_map: gradient position to color table address
// Four stages: scale and round, truncate to an index, fold the magnitude,
// reduce modulo 2N-1; the spread rule finishes on the last stage's output.
// ----------------------------------------------------------------------------
`default_nettype none

module lgsf_map
    import lgsf_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire logic                       i_inject,
    input  wire logic                       i_last,
    input  wire logic signed [POS_W-1:0]    i_pos,
    input  wire logic        [MODE_W-1:0]   i_spread_mode,
    output logic             [TABLE_AW-1:0] o_addr,
    output t_map_stat                       o_stat
);

    localparam logic signed [SCALED_W-1:0] ROUND_HALF = SCALED_W'(1 << (FRAC_W - 1));
    localparam logic signed [SCALED_W-1:0] TRUNC_BIAS = SCALED_W'((1 << FRAC_W) - 1);
    localparam logic [DIG_W-1:0]           REFL_LIM   = '1;
    localparam logic [DIG_W-1:0]           TBL_N      = DIG_W'(TABLE_SIZE);

    function automatic logic [FOLD_W-1:0] fold_digits(input logic [MAG_W-1:0] m);
        logic [NDIG*DIG_W-1:0] p;
        logic [FOLD_W-1:0]     s;
        p = (NDIG*DIG_W)'(m);
        s = '0;
        for (int i = 0; i < NDIG; i++) begin
            s = s + FOLD_W'(p[i*DIG_W +: DIG_W]);
        end
        return s;
    endfunction

    // Stage A
    logic                       r_a_v, r_a_last;
    logic signed [SCALED_W-1:0] r_a_t;
    logic signed [SCALED_W-1:0] n_a_t;
    logic signed [SCALED_W-1:0] pos_ext;

    // Stage B
    logic                       r_b_v, r_b_last;
    logic signed [IDX_W-1:0]    r_b_idx;
    logic        [MAG_W-1:0]    r_b_mag;
    logic signed [SCALED_W-1:0] t_adj;
    logic signed [IDX_W-1:0]    n_b_idx;

    // Stage C
    logic                       r_c_v, r_c_last, r_c_refl, r_c_neg;
    logic [TABLE_AW-1:0]        r_c_sel;
    logic [FOLD_W-1:0]          r_c_sum;
    logic                       b_in_range;
    logic [TABLE_AW-1:0]        n_c_sel;
    logic                       n_c_refl;

    // Stage D
    logic                       r_d_v, r_d_last, r_d_refl, r_d_neg;
    logic [TABLE_AW-1:0]        r_d_sel;
    logic [DIG_W-1:0]           r_d_rem;
    logic [DIG_W:0]             fold2;
    logic [DIG_W-1:0]           n_d_rem;

    logic [DIG_W-1:0]           mir_a, mir_b;

    // Stage A: pos*(N-1) + 1/2 as shift and subtract
    assign pos_ext = SCALED_W'(i_pos);
    assign n_a_t   = (pos_ext <<< TABLE_AW) - pos_ext + ROUND_HALF;

    // Stage B: divide by 2^16 truncating toward zero
    assign t_adj   = r_a_t[SCALED_W-1] ? (r_a_t + TRUNC_BIAS) : r_a_t;
    assign n_b_idx = t_adj[SCALED_W-1:FRAC_W];

    // Stage C: clamp or wrap for pad and repeat; flag reflect
    assign b_in_range = !r_b_idx[IDX_W-1] && (r_b_idx[IDX_W-1:TABLE_AW] == '0);

    always_comb begin
        n_c_sel  = r_b_idx[TABLE_AW-1:0];
        n_c_refl = 1'b0;
        if (!b_in_range) begin
            case (i_spread_mode)
                SPREAD_REPEAT: begin
                    n_c_sel = r_b_idx[TABLE_AW-1:0];
                end
                SPREAD_REFLECT: begin
                    n_c_refl = 1'b1;
                end
                default: begin
                    n_c_sel = r_b_idx[IDX_W-1] ? '0 : '1;
                end
            endcase
        end
    end

    // Stage D: second fold and final correction gives |idx| mod (2N-1)
    assign fold2   = (DIG_W+1)'(r_c_sum[DIG_W-1:0]) + (DIG_W+1)'(r_c_sum >> DIG_W);
    assign n_d_rem = (fold2 >= (DIG_W+1)'(REFL_LIM)) ? DIG_W'(fold2 - (DIG_W+1)'(REFL_LIM))
                                                     : fold2[DIG_W-1:0];

    // Mirror: negative side wraps up from the limit, upper half folds back
    assign mir_a  = (r_d_neg && (r_d_rem != '0)) ? (REFL_LIM - r_d_rem) : r_d_rem;
    assign mir_b  = (mir_a >= TBL_N) ? (REFL_LIM - mir_a) : mir_a;
    assign o_addr = r_d_refl ? mir_b[TABLE_AW-1:0] : r_d_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else if (i_adv) begin
            r_a_v <= i_inject;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_t    <= n_a_t;
            r_a_last <= i_last;

            r_b_idx  <= n_b_idx;
            r_b_mag  <= n_b_idx[IDX_W-1] ? MAG_W'(-n_b_idx) : MAG_W'(n_b_idx);
            r_b_last <= r_a_last;

            r_c_sum  <= fold_digits(r_b_mag);
            r_c_sel  <= n_c_sel;
            r_c_refl <= n_c_refl;
            r_c_neg  <= r_b_idx[IDX_W-1];
            r_c_last <= r_b_last;

            r_d_rem  <= n_d_rem;
            r_d_sel  <= r_c_sel;
            r_d_refl <= r_c_refl;
            r_d_neg  <= r_c_neg;
            r_d_last <= r_c_last;
        end
    end

    assign o_stat.busy     = r_a_v | r_b_v | r_c_v | r_d_v;
    assign o_stat.rd_valid = r_d_v;
    assign o_stat.rd_last  = r_d_last;

endmodule

`default_nettype wire

// File: sv/linear_gradient_span_fetch.sv
// ----------------------------------------------------------------------------
// linear_gradient_span_fetch: linear gradient span generator
// Takes table writes and span requests, steps the gradient position along
// the span and emits one color table entry per pixel, last pixel flagged.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  --------  ------------------------  -------------------------------------
//  request   i_valid / o_ready         operation, span x/y/count, table idx/color
//  pixel     o_valid / i_ready         pixel_color, last_pixel
//  config    i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
//  A span of n pixels (count clamped to 64) runs through the setup states
//  MUL_X, MUL_Y, SUM and LOAD, in which one shared 32x14 multiplier forms
//  step_x*(2x+1) and step_y*(2y+1) and the sum is halved; then RUN feeds one
//  pixel per cycle from the position accumulator, unless the pixel channel
//  stalls, through the index stages and the table read, and DRAIN waits
//  until the last pixel has left the output before returning to idle. A span
//  with zero count returns at once. o_ready is high only between requests.
//  A stall on the pixel channel freezes the whole index pipeline and the
//  table read. Reset is synchronous, active low, and clears the configuration,
//  position and valid registers and the sequencer; the table is not cleared
//  and must be written before use.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_gradient_span_fetch
    import lgsf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_operation,
    input  wire logic [COORD_W-1:0]   i_span_x,
    input  wire logic [COORD_W-1:0]   i_span_y,
    input  wire logic [COUNT_W-1:0]   i_span_count,
    input  wire logic [TIDX_W-1:0]    i_table_index,
    input  wire logic [COLOR_W-1:0]   i_table_color,

    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic      [COLOR_W-1:0]   o_pixel_color,
    output logic                      o_last_pixel,

    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int MULB_W = COORD_W + 2;
    localparam int PROD_W = STEP_W + MULB_W;
    localparam int ACC_W  = PROD_W + 2;

    localparam logic signed [ACC_W-1:0] ACC_POS_MAX = ACC_W'({1'b0, {(POS_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] ACC_POS_MIN = -ACC_POS_MAX - ACC_W'(1);

    // Clamp a wide signed value into the 40-bit position range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        if (v > ACC_POS_MAX) begin
            c = ACC_POS_MAX;
        end else if (v < ACC_POS_MIN) begin
            c = ACC_POS_MIN;
        end else begin
            c = v;
        end
        return c[POS_W-1:0];
    endfunction

    // Configuration
    logic signed [STEP_W-1:0]  r_step_x, r_step_y, r_start_off;
    logic        [MODE_W-1:0]  r_spread_mode;

    // Sequencer and span state
    t_state                    r_state, n_state;
    logic [COORD_W-1:0]        r_x, r_y;
    logic [COUNT_W-1:0]        r_left;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [POS_W-1:0]   r_pos;

    // Output register
    logic                      r_out_v, r_out_last;

    // Sequencer decode
    logic                      mul_en, mul_sel_y, acc_init, acc_add, pos_load, inject_run;

    logic                      req_take, span_take, tbl_take, tbl_ok;
    logic [COUNT_W-1:0]        count_sat;
    logic                      adv, inject, drain_done;

    logic signed [STEP_W-1:0]  mul_a;
    logic signed [MULB_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [ACC_W-1:0]   n_acc;
    logic signed [POS_W-1:0]   n_pos;

    logic [TABLE_AW-1:0]       rd_addr;
    t_map_stat                 map_stat;
    logic                      ram_re;

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    assign o_ready   = (r_state == ST_IDLE);
    assign req_take  = i_valid && o_ready;
    assign count_sat = (i_span_count > COUNT_W'(MAX_SPAN)) ? COUNT_W'(MAX_SPAN) : i_span_count;
    assign span_take = req_take && (i_operation == OP_SPAN) && (i_span_count != '0);
    // Drop table writes that fall past the end of the table
    assign tbl_ok    = (32'(i_table_index) < 32'(TABLE_SIZE));
    assign tbl_take  = req_take && (i_operation == OP_TABLE_WR) && tbl_ok;

    // Pipeline advances whenever the output slot is free or being taken
    assign adv        = !r_out_v || i_ready;
    assign inject     = inject_run && adv;
    assign drain_done = !map_stat.busy && !r_out_v;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (span_take) begin
                    n_state = ST_MUL_X;
                end
            end
            ST_MUL_X: begin
                n_state = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (inject && (r_left == COUNT_W'(1))) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: control decode
    // ------------------------------------------------------------------
    always_comb begin
        mul_en     = 1'b0;
        mul_sel_y  = 1'b0;
        acc_init   = 1'b0;
        acc_add    = 1'b0;
        pos_load   = 1'b0;
        inject_run = 1'b0;
        case (r_state)
            ST_MUL_X: begin
                mul_en   = 1'b1;
                acc_init = 1'b1;
            end
            ST_MUL_Y: begin
                mul_en    = 1'b1;
                mul_sel_y = 1'b1;
                acc_add   = 1'b1;
            end
            ST_SUM: begin
                acc_add = 1'b1;
            end
            ST_LOAD: begin
                pos_load = 1'b1;
            end
            ST_RUN: begin
                inject_run = 1'b1;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Shared multiplier and start position
    // step*(2c+1): the coordinate operand is always positive and odd
    // ------------------------------------------------------------------
    assign mul_a  = mul_sel_y ? r_step_y : r_step_x;
    assign mul_b  = mul_sel_y ? {1'b0, r_y, 1'b1} : {1'b0, r_x, 1'b1};
    assign n_prod = mul_a * mul_b;

    // Seed with 2*start_offset, then add both products
    assign n_acc  = acc_init ? (ACC_W'(r_start_off) <<< 1) : (r_acc + ACC_W'(r_prod));

    // Halve rounding down for the first pixel, then add step_x per pixel
    assign n_pos  = pos_load ? sat_pos(r_acc >>> 1)
                             : sat_pos(ACC_W'(r_pos) + ACC_W'(r_step_x));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_step_x      <= '0;
            r_step_y      <= '0;
            r_start_off   <= '0;
            r_spread_mode <= SPREAD_PAD;
            r_left        <= '0;
            r_pos         <= '0;
            r_out_v       <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_STEP_X:       r_step_x      <= i_cfg_data[STEP_W-1:0];
                    CFG_STEP_Y:       r_step_y      <= i_cfg_data[STEP_W-1:0];
                    CFG_START_OFFSET: r_start_off   <= i_cfg_data[STEP_W-1:0];
                    CFG_SPREAD_MODE:  r_spread_mode <= i_cfg_data[MODE_W-1:0];
                    default:          r_spread_mode <= r_spread_mode;
                endcase
            end

            // Hold the pixel count; drop one per injected pixel
            if (span_take) begin
                r_left <= count_sat;
            end else if (inject) begin
                r_left <= r_left - COUNT_W'(1);
            end

            if (pos_load || inject) begin
                r_pos <= n_pos;
            end

            if (adv) begin
                r_out_v <= map_stat.rd_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (span_take) begin
            r_x <= i_span_x;
            r_y <= i_span_y;
        end
        if (mul_en) begin
            r_prod <= n_prod;
        end
        if (acc_init || acc_add) begin
            r_acc <= n_acc;
        end
        if (adv) begin
            r_out_last <= map_stat.rd_last;
        end
    end

    // ------------------------------------------------------------------
    // Index pipeline and color table
    // ------------------------------------------------------------------
    lgsf_map u_map (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_inject      (inject),
        .i_last        (r_left == COUNT_W'(1)),
        .i_pos         (r_pos),
        .i_spread_mode (r_spread_mode),
        .o_addr        (rd_addr),
        .o_stat        (map_stat)
    );

    // Read only when the output slot moves, so a stall holds the data
    assign ram_re = adv && map_stat.rd_valid;

    lgsf_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_take),
        .i_waddr (TABLE_AW'(i_table_index)),
        .i_wdata (i_table_color),
        .i_re    (ram_re),
        .i_raddr (rd_addr),
        .o_rdata (o_pixel_color)
    );

    assign o_valid      = r_out_v;
    assign o_last_pixel = r_out_last;

endmodule

`default_nettype wire

// File: sim/linear_gradient_span_fetch_tb.sv
// ----------------------------------------------------------------------------
// linear_gradient_span_fetch_tb: self-checking bench for the span fetch block
// Preloads the color table, then sends directed and random requests under a
// series of register settings, with random stalls on both channels and one
// long hold-off on the pixel side. A shadow model of the gradient stepping,
// index mapping and spread rules predicts every pixel, and a monitor checks
// the pixels in order.
// ----------------------------------------------------------------------------

module linear_gradient_span_fetch_tb;
    import lgsf_pkg::*;

    // Spare mode code, behaves as pad
    localparam logic [MODE_W-1:0] SPREAD_PAD_ALIAS = 2'd3;
    // Quiet cycles after the last pixel before touching the registers
    localparam int SETTLE_CYCLES    = 16;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int RANDOM_PHASES    = 3;
    localparam int PHASE_REQUESTS   = 3;

    typedef struct {
        logic                op;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COUNT_W-1:0]  count;
        logic [TIDX_W-1:0]   tidx;
        logic [COLOR_W-1:0]  color;
    } t_request;

    typedef struct {
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_pixel;

    // ------------------------------------------------------------------
    // Block ports, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic                 o_ready;
    logic                 i_operation   = OP_SPAN;
    logic [COORD_W-1:0]   i_span_x      = '0;
    logic [COORD_W-1:0]   i_span_y      = '0;
    logic [COUNT_W-1:0]   i_span_count  = '0;
    logic [TIDX_W-1:0]    i_table_index = '0;
    logic [COLOR_W-1:0]   i_table_color = '0;
    logic                 o_valid;
    logic                 i_ready       = 1'b0;
    logic [COLOR_W-1:0]   o_pixel_color;
    logic                 o_last_pixel;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data    = '0;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_request pending_reqs[$];
    t_pixel   expected_pixels[$];
    int       reqs_queued = 0;
    int       reqs_taken  = 0;
    int       mismatches  = 0;
    int       pixels_seen = 0;
    int       req_gap     = 0;
    int       rx_gap      = 0;
    logic     idle_on     = 1'b1;
    logic     rx_hold     = 1'b0;
    logic     long_hold_go = 1'b0;

    // Shadow copy of the registers and the color table
    logic signed [STEP_W-1:0] gx_step  = '0;
    logic signed [STEP_W-1:0] gy_step  = '0;
    logic signed [STEP_W-1:0] g_offset = '0;
    logic [MODE_W-1:0]        g_mode   = SPREAD_PAD;
    logic [COLOR_W-1:0]       palette_model [TABLE_SIZE];

    linear_gradient_span_fetch dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_span_x      (i_span_x),
        .i_span_y      (i_span_y),
        .i_span_count  (i_span_count),
        .i_table_index (i_table_index),
        .i_table_color (i_table_color),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Gradient prediction
    // ------------------------------------------------------------------

    // Saturate to the signed 40-bit position range
    function automatic longint clamp_pos(longint v);
        longint hi;
        hi = (longint'(1) <<< (POS_W - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // Map a signed Q24.16 position to a table entry under the current spread rule
    function automatic logic [COLOR_W-1:0] palette_at(longint pos);
        longint n;
        longint lim;
        longint idx;
        n   = TABLE_SIZE;
        lim = 2 * n - 1;
        // round to nearest entry, truncating toward zero like the hardware
        idx = (pos * (n - 1) + 32768) / 65536;
        if (idx < 0 || idx >= n) begin
            case (g_mode)
                SPREAD_REFLECT: begin
                    idx = idx % lim;
                    if (idx < 0)
                        idx += lim;
                    if (idx >= n)
                        idx = lim - idx;
                end
                SPREAD_REPEAT: begin
                    idx = idx % n;
                    if (idx < 0)
                        idx += n;
                end
                default: idx = (idx < 0) ? 0 : n - 1;
            endcase
        end
        return palette_model[idx];
    endfunction

    // Expand one span request into its expected pixels
    function automatic void render_span(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                        logic [COUNT_W-1:0] count);
        longint xs;
        longint ys;
        longint sx;
        longint sy;
        longint so;
        longint pos;
        int     n;
        t_pixel px;
        xs  = x;
        ys  = y;
        sx  = gx_step;
        sy  = gy_step;
        so  = g_offset;
        n   = (count > MAX_SPAN) ? MAX_SPAN : count;
        // pixel center: exact doubled sum, then floor-halve
        pos = clamp_pos((sx * (2 * xs + 1) + sy * (2 * ys + 1) + 2 * so) >>> 1);
        for (int i = 0; i < n; i++) begin
            px.color = palette_at(pos);
            px.last  = (i == n - 1);
            expected_pixels.push_back(px);
            pos = clamp_pos(pos + sx);
        end
    endfunction

    task automatic report_mismatch(string what, logic [COLOR_W-1:0] got,
                                   logic [COLOR_W-1:0] want);
        mismatches++;
        $display("mismatch: %s at pixel %0d, got %h, want %h",
                 what, pixels_seen, got, want);
    endtask

    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(9, 30);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: offer queued requests, idle at random in between
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : request_driver
        t_request nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            req_gap <= 0;
        end else if (!i_valid || o_ready) begin
            // slot is free: either nothing offered or the request just went in
            if (req_gap != 0) begin
                i_valid <= 1'b0;
                req_gap <= req_gap - 1;
            end else if (pending_reqs.size() != 0) begin
                nxt = pending_reqs.pop_front();
                i_operation   <= nxt.op;
                i_span_x      <= nxt.x;
                i_span_y      <= nxt.y;
                i_span_count  <= nxt.count;
                i_table_index <= nxt.tidx;
                i_table_color <= nxt.color;
                i_valid       <= 1'b1;
                req_gap       <= pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel receiver: random stalls, plus the long hold-off when asked
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : pixel_receiver
        int g;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_gap  <= 0;
        end else if (rx_hold) begin
            i_ready <= 1'b0;
        end else if (rx_gap != 0) begin
            i_ready <= 1'b0;
            rx_gap  <= rx_gap - 1;
        end else if (o_valid && i_ready) begin
            g = pick_gap();
            rx_gap  <= g;
            i_ready <= (g == 0);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Hold off the pixel side for a long stretch while requests keep coming,
    // so the block backs up and stalls its request channel.
    initial begin : receiver_hold_off
        wait (long_hold_go);
        repeat (40) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted request, check each accepted pixel
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_pixel want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                reqs_taken++;
                if (i_operation == OP_TABLE_WR)
                    palette_model[i_table_index] = i_table_color;
                else
                    render_span(i_span_x, i_span_y, i_span_count);
            end
            if (o_valid && i_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("pixel with none expected", o_pixel_color, '0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_pixel_color !== want.color)
                        report_mismatch("pixel_color", o_pixel_color, want.color);
                    if (o_last_pixel !== want.last)
                        report_mismatch("last_pixel", COLOR_W'(o_last_pixel),
                                        COLOR_W'(want.last));
                end
                pixels_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_write(logic [TIDX_W-1:0] idx, logic [COLOR_W-1:0] color);
        t_request r;
        r.op    = OP_TABLE_WR;
        r.x     = COORD_W'($urandom);
        r.y     = COORD_W'($urandom);
        r.count = COUNT_W'($urandom);
        r.tidx  = idx;
        r.color = color;
        pending_reqs.push_back(r);
        reqs_queued++;
    endtask

    task automatic queue_span(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [COUNT_W-1:0] count);
        t_request r;
        r.op    = OP_SPAN;
        r.x     = x;
        r.y     = y;
        r.count = count;
        r.tidx  = TIDX_W'($urandom);
        r.color = $urandom;
        pending_reqs.push_back(r);
        reqs_queued++;
    endtask

    // Wait until every request is in and every pixel is out, then settle
    task automatic wait_idle();
        while (reqs_taken != reqs_queued || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Reprogram all registers once the block has gone quiet
    task automatic set_config(logic [STEP_W-1:0] sx, logic [STEP_W-1:0] sy,
                              logic [STEP_W-1:0] off, logic [MODE_W-1:0] mode);
        wait_idle();
        write_reg(CFG_STEP_X, sx);
        write_reg(CFG_STEP_Y, sy);
        write_reg(CFG_START_OFFSET, off);
        write_reg(CFG_SPREAD_MODE, CFG_DAT_W'(mode));
        gx_step  = sx;
        gy_step  = sy;
        g_offset = off;
        g_mode   = mode;
    endtask

    // Mostly small steps so indexes stay near the table, some huge ones
    function automatic logic [STEP_W-1:0] random_step();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(0, 127) - 64;
            3, 4, 5: return $urandom_range(0, 8191) - 4096;
            6, 7:    return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
            8:       return $urandom;
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    task automatic queue_random();
        int r;
        int c;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            queue_write(TIDX_W'($urandom), $urandom);
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60)
                c = $urandom_range(1, 12);
            else if (r < 88)
                c = $urandom_range(13, MAX_SPAN);
            else if (r < 94)
                c = $urandom_range(MAX_SPAN + 1, 127);
            else
                c = 0;
            queue_span(COORD_W'($urandom), COORD_W'($urandom), COUNT_W'(c));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the whole table so no span ever reads an unwritten entry
        for (int i = 0; i < TABLE_SIZE; i++)
            queue_write(TIDX_W'(i), $urandom);

        // Ramp of one entry per pixel, pad
        set_config(32'd257, 32'd0, 32'd0, SPREAD_PAD);
        queue_span(12'd0, 12'd0, 7'd1);
        queue_span(12'd4095, 12'd4095, 7'd64);
        queue_span(12'd0, 12'd0, 7'd0);             // zero count: no pixels
        queue_span(12'd5, 12'd0, 7'd127);           // count saturates to max span
        queue_span(12'd0, 12'd0, 7'd65);
        queue_write(8'd0, 32'h0000_0000);
        queue_write(8'd255, 32'hFFFF_FFFF);
        queue_span(12'd0, 12'd0, 7'd3);
        queue_span(12'd250, 12'd0, 7'd10);          // runs off the top: clamp

        // Falling ramp, repeat wraps negative indexes
        set_config(-32'sd257, 32'd0, 32'd0, SPREAD_REPEAT);
        queue_span(12'd0, 12'd0, 7'd40);
        queue_span(12'd4095, 12'd0, 7'd2);
        queue_span(12'd0, 12'd4095, 7'd5);

        // Extreme registers, reflect, position saturates both ways
        set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, SPREAD_REFLECT);
        queue_span(12'd4095, 12'd0, 7'd8);
        queue_span(12'd0, 12'd4095, 7'd8);
        queue_span(12'd2048, 12'd2048, 7'd4);

        // Spare mode code acts as pad
        set_config(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, SPREAD_PAD_ALIAS);
        queue_span(12'd4095, 12'd4095, 7'd64);
        queue_span(12'd0, 12'd0, 7'd2);

        // Reflect from a negative start through several mirror folds
        set_config(32'd1000, 32'd500, 32'hFFFE_0000, SPREAD_REFLECT);
        queue_span(12'd100, 12'd30, 7'd64);
        queue_span(12'd4000, 12'd10, 7'd64);
        queue_span(12'd0, 12'd0, 7'd64);

        // Random settings and requests; one phase runs without idling,
        // another opens with two full spans and gets the long hold-off
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_config(random_step(), random_step(), random_step(),
                       MODE_W'($urandom_range(0, 3)));
            idle_on <= (ph != 2);
            if (ph == 1) begin
                long_hold_go <= 1'b1;
                queue_span(COORD_W'($urandom), COORD_W'($urandom), COUNT_W'(MAX_SPAN));
                queue_span(COORD_W'($urandom), COORD_W'($urandom), COUNT_W'(MAX_SPAN));
            end
            for (int k = 0; k < PHASE_REQUESTS; k++)
                queue_random();
        end

        wait_idle();
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("linear_gradient_span_fetch regression: pass");
        else
            $display("linear_gradient_span_fetch regression: fail");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("linear_gradient_span_fetch regression: fail");
        $finish;
    end

endmodule
